@@ rtl/core/lz77d_pkg.sv @@
// shared types and constants of the lz77 type 0x10 decompressor
`default_nettype none
package lz77d_pkg;

  // parse and copy phases of the decoder
  typedef enum logic [2:0] {
    PH_START,
    PH_MAGIC,
    PH_TYPE,
    PH_SIZE,
    PH_DATA,
    PH_SECOND,
    PH_DRAIN,
    PH_COPY
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_NOT_COMP   = 3'd1,
    ST_BAD_TYPE   = 3'd2,
    ST_ZERO_SIZE  = 3'd3,
    ST_BAD_OFFSET = 3'd4,
    ST_SHORT      = 3'd5
  } status_t;

  localparam logic [7:0] MAGIC_L    = 8'h4C;  // 'L'
  localparam logic [7:0] HDR_RAW    = 8'h10;
  localparam logic [7:0] TYPE_MASK  = 8'hF0;
  localparam logic [7:0] TYPE_VALUE = 8'h10;
  localparam logic [4:0] MIN_MATCH  = 5'd3;

  // remaining magic bytes after the leading 'L'
  function automatic logic [7:0] magic_tail(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h5A;  // 'Z'
      2'd1:    ch = 8'h37;  // '7'
      2'd2:    ch = 8'h37;  // '7'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lz77d_if.sv @@
// valid/ready channel interfaces for compressed input and decoded output
`default_nettype none
interface lz77d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface lz77d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lz77d_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module lz77d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lz77_type10_decompressor_top.sv @@
// lz77 type 0x10 decompressor: header parse, token decode and window copy
//
// Compressed bytes enter on the stream channel, one word per handshake, with
// end_of_input marking the final byte. Decoded words leave on the result
// channel: a data byte with status 0, or one error word (byte 0, nonzero
// status) that closes the stream. last is set on the final word of a stream.
// Header, flag and first token bytes produce no data word. A literal's word
// appears in the output register the cycle after the literal is taken. A
// back-reference of n bytes (n up to 18) is copied in order: the second token
// byte is accepted, the first window read is issued, then one byte per cycle
// comes from the 4096-byte window ram while the output register is free; a
// byte written and read in the same cycle is forwarded. No new input word is
// taken while a copy is running.
// A stalled receiver holds the output register; the block then takes no input
// and pauses any copy until the word is taken. Reset clears the parser to wait
// for a new header; the window ram is not cleared and needs no clearing pass.
// After a stream ends, bytes up to the one marked end_of_input are dropped.
`default_nettype none
module lz77_type10_decompressor_top #(
  parameter int WINDOW_DEPTH = 4096
) (
  input wire logic     clk,
  input wire logic     rst,
  lz77d_in_if.sink     stream,
  lz77d_out_if.source  result
);

  import lz77d_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  // parser state
  phase_t        state, state_next;
  logic [AW-1:0] wp, wp_next;
  logic [23:0]   produced, produced_next;
  logic [23:0]   target, target_next;
  logic [1:0]    hdr_idx, hdr_idx_next;
  logic [7:0]    flag_bits, flag_bits_next;
  logic [3:0]    flags_left, flags_left_next;
  logic [7:0]    first_byte, first_byte_next;

  // copy engine state
  logic          eoi_hold, eoi_hold_next;
  logic [AW-1:0] src_ptr, src_ptr_next;
  logic [4:0]    issue_left, issue_left_next;
  logic [4:0]    cons_left, cons_left_next;
  logic          rd_pend, rd_pend_next;
  logic          fwd_hit, fwd_hit_next;
  logic [7:0]    fwd_data, fwd_data_next;

  // output register
  logic          o_valid, o_valid_next;
  logic [7:0]    o_byte, o_byte_next;
  logic [2:0]    o_status, o_status_next;
  logic          o_last, o_last_next;

  // ram ports
  logic          ram_we, ram_re;
  logic [7:0]    ram_wdata, ram_rdata;

  // working values
  logic          out_free, in_acc, eoi_now;
  logic          fail, fin, consume, issue;
  status_t       fail_code;
  logic [7:0]    b;
  logic [23:0]   prod_inc, remaining, size_new;
  logic [12:0]   offset;
  logic [4:0]    length, count, copy_count;
  logic [7:0]    copy_byte;

  assign out_free     = !o_valid || result.ready;
  assign stream.ready = (state != PH_COPY) && out_free;
  assign in_acc       = stream.valid && stream.ready;
  assign b            = stream.in_byte;
  assign prod_inc     = produced + 24'd1;

  // back-reference fields
  assign length     = {1'b0, first_byte[7:4]} + MIN_MATCH;
  assign offset     = {1'b0, first_byte[3:0], b} + 13'd1;
  assign remaining  = target - produced;
  assign copy_count = ({19'd0, length} < remaining) ? length : remaining[4:0];
  assign count      = copy_count;

  // copy data, forwarded when the read hit the entry written that cycle
  assign copy_byte = fwd_hit ? fwd_data : ram_rdata;
  assign consume   = (state == PH_COPY) && rd_pend && out_free;
  assign issue     = (state == PH_COPY) && (issue_left != 5'd0) && (!rd_pend || consume);

  assign result.valid    = o_valid;
  assign result.out_byte = o_byte;
  assign result.status   = o_status;
  assign result.last     = o_last;

  // history window
  lz77d_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (src_ptr),
    .rdata (ram_rdata)
  );

  // next state and outputs
  always_comb begin
    state_next      = state;
    wp_next         = wp;
    produced_next   = produced;
    target_next     = target;
    hdr_idx_next    = hdr_idx;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    first_byte_next = first_byte;
    eoi_hold_next   = eoi_hold;
    src_ptr_next    = src_ptr;
    issue_left_next = issue_left;
    cons_left_next  = cons_left;
    rd_pend_next    = rd_pend;
    fwd_hit_next    = fwd_hit;
    fwd_data_next   = fwd_data;
    o_valid_next    = result.ready ? 1'b0 : o_valid;
    o_byte_next     = o_byte;
    o_status_next   = o_status;
    o_last_next     = o_last;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_wdata       = b;
    fail            = 1'b0;
    fail_code       = ST_SHORT;
    fin             = 1'b0;
    size_new        = target;
    eoi_now         = (state == PH_COPY) ? eoi_hold : stream.end_of_input;

    if (in_acc) begin
      unique case (state)
        PH_START: begin
          hdr_idx_next = 2'd0;
          if (b == MAGIC_L) begin
            state_next = PH_MAGIC;
          end else if (b == HDR_RAW) begin
            state_next = PH_SIZE;
          end else begin
            fail      = 1'b1;
            fail_code = ST_NOT_COMP;
          end
          if (eoi_now) fail = 1'b1;
        end
        PH_MAGIC: begin
          if (b != magic_tail(hdr_idx)) begin
            fail      = 1'b1;
            fail_code = ST_NOT_COMP;
          end else begin
            hdr_idx_next = hdr_idx + 2'd1;
            if (hdr_idx == 2'd2) state_next = PH_TYPE;
            if (eoi_now) fail = 1'b1;
          end
        end
        PH_TYPE: begin
          if ((b & TYPE_MASK) != TYPE_VALUE) begin
            fail      = 1'b1;
            fail_code = ST_BAD_TYPE;
          end else begin
            state_next   = PH_SIZE;
            hdr_idx_next = 2'd0;
            if (eoi_now) fail = 1'b1;
          end
        end
        PH_SIZE: begin
          case (hdr_idx)
            2'd0:    size_new = target | {16'd0, b};
            2'd1:    size_new = target | {8'd0, b, 8'd0};
            default: size_new = target | {b, 16'd0};
          endcase
          target_next  = size_new;
          hdr_idx_next = hdr_idx + 2'd1;
          if (hdr_idx == 2'd2) begin
            hdr_idx_next = 2'd0;
            if (size_new == 24'd0) begin
              fail      = 1'b1;
              fail_code = ST_ZERO_SIZE;
            end else begin
              state_next      = PH_DATA;
              flags_left_next = 4'd0;
              if (eoi_now) fail = 1'b1;
            end
          end else if (eoi_now) begin
            fail = 1'b1;
          end
        end
        PH_DATA: begin
          if (flags_left == 4'd0) begin
            flag_bits_next  = b;
            flags_left_next = 4'd8;
            if (eoi_now) fail = 1'b1;
          end else begin
            flag_bits_next  = {flag_bits[6:0], 1'b0};
            flags_left_next = flags_left - 4'd1;
            if (flag_bits[7]) begin
              first_byte_next = b;
              state_next      = PH_SECOND;
              if (eoi_now) fail = 1'b1;
            end else if (eoi_now && (prod_inc < target)) begin
              fail = 1'b1;
            end else begin
              // literal byte
              ram_we        = 1'b1;
              ram_wdata     = b;
              wp_next       = wp + AW'(1);
              produced_next = prod_inc;
              o_valid_next  = 1'b1;
              o_byte_next   = b;
              o_status_next = ST_DATA;
              o_last_next   = (prod_inc == target);
              fin           = (prod_inc == target);
            end
          end
        end
        PH_SECOND: begin
          if ({11'd0, offset} > produced) begin
            fail      = 1'b1;
            fail_code = ST_BAD_OFFSET;
          end else if (eoi_now && ({19'd0, count} < remaining)) begin
            fail = 1'b1;
          end else begin
            state_next      = PH_COPY;
            src_ptr_next    = wp - offset[AW-1:0];
            issue_left_next = count;
            cons_left_next  = count;
            eoi_hold_next   = eoi_now;
            rd_pend_next    = 1'b0;
          end
        end
        PH_DRAIN: begin
          fin = 1'b1;
        end
        default: begin
          state_next = state;
        end
      endcase
    end

    // window copy: one read issued and one byte written per cycle while the output register is free
    if (state == PH_COPY) begin
      if (consume) begin
        ram_we         = 1'b1;
        ram_wdata      = copy_byte;
        wp_next        = wp + AW'(1);
        produced_next  = prod_inc;
        cons_left_next = cons_left - 5'd1;
        o_valid_next   = 1'b1;
        o_byte_next    = copy_byte;
        o_status_next  = ST_DATA;
        o_last_next    = (prod_inc == target);
        rd_pend_next   = 1'b0;
        if (cons_left == 5'd1) begin
          state_next = PH_DATA;
          fin        = (prod_inc == target);
        end
      end
      if (issue) begin
        ram_re          = 1'b1;
        src_ptr_next    = src_ptr + AW'(1);
        issue_left_next = issue_left - 5'd1;
        rd_pend_next    = 1'b1;
        fwd_hit_next    = consume && (src_ptr == wp);
        fwd_data_next   = copy_byte;
      end
    end

    // error word
    if (fail) begin
      o_valid_next  = 1'b1;
      o_byte_next   = 8'd0;
      o_status_next = fail_code;
      o_last_next   = 1'b1;
    end

    // end of stream: restart on end of input, else drop bytes until it
    if (fail || fin) begin
      if (eoi_now) begin
        state_next      = PH_START;
        wp_next         = '0;
        produced_next   = 24'd0;
        target_next     = 24'd0;
        hdr_idx_next    = 2'd0;
        flag_bits_next  = 8'd0;
        flags_left_next = 4'd0;
        first_byte_next = 8'd0;
      end else begin
        state_next = PH_DRAIN;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= PH_START;
      wp         <= '0;
      produced   <= 24'd0;
      target     <= 24'd0;
      hdr_idx    <= 2'd0;
      flag_bits  <= 8'd0;
      flags_left <= 4'd0;
      first_byte <= 8'd0;
      eoi_hold   <= 1'b0;
      issue_left <= 5'd0;
      cons_left  <= 5'd0;
      rd_pend    <= 1'b0;
      fwd_hit    <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      produced   <= produced_next;
      target     <= target_next;
      hdr_idx    <= hdr_idx_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      first_byte <= first_byte_next;
      eoi_hold   <= eoi_hold_next;
      issue_left <= issue_left_next;
      cons_left  <= cons_left_next;
      rd_pend    <= rd_pend_next;
      fwd_hit    <= fwd_hit_next;
      o_valid    <= o_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_ptr  <= src_ptr_next;
    fwd_data <= fwd_data_next;
    o_byte   <= o_byte_next;
    o_status <= o_status_next;
    o_last   <= o_last_next;
  end

endmodule
`default_nettype wire

@@ sim/lz77_stream_checker.sv @@
// watches both channels, predicts the decoded words and compares them
module lz77_stream_checker (
  input  logic        clk,
  input  logic        rst,
  lz77d_in_if         stream,
  lz77d_out_if        result,
  output int          mismatch_count,
  output int          pending_words,
  output int          checked_words,
  output int          error_words,
  output int          streams_closed
);
  import lz77d_pkg::*;

  localparam int          WINDOW_DEPTH = 4096;
  localparam logic [23:0] MAGIC_TAIL   = "Z77";

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } dec_word_t;

  // decoder copy: window, pointers, header and token state
  logic [7:0]  history [WINDOW_DEPTH];
  logic [11:0] win_ptr;
  logic [23:0] produced;
  logic [23:0] target;
  phase_t      phase;
  logic [2:0]  hdr_idx;
  logic [7:0]  flags;
  logic [3:0]  flags_left;
  logic [7:0]  token_hi;

  dec_word_t decoded_due[$];

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) history[i] = 8'h00;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic restart_stream();
    win_ptr    = '0;
    produced   = '0;
    target     = '0;
    phase      = PH_START;
    hdr_idx    = '0;
    flags      = '0;
    flags_left = '0;
    token_hi   = '0;
  endtask

  // a finished stream either restarts or drops bytes until end of input
  task automatic close_stream(input logic eoi);
    if (eoi) begin
      restart_stream();
    end else begin
      phase = PH_DRAIN;
    end
  endtask

  task automatic raise_error(input status_t st, input logic eoi);
    decoded_due.insert(decoded_due.size(), '{data: 8'h00, status: st, last: 1'b1});
    close_stream(eoi);
  endtask

  task automatic emit_byte(input logic [7:0] b);
    history[win_ptr] = b;
    win_ptr  = win_ptr + 12'd1;
    produced = produced + 24'd1;
    decoded_due.insert(decoded_due.size(),
                       '{data: b, status: ST_DATA, last: produced == target});
  endtask

  // one compressed byte through the decoder, queueing the words it yields
  task automatic decode_compressed_byte(input logic [7:0] b, input logic eoi);
    logic        is_ref;
    logic [4:0]  len;
    logic [12:0] off;
    logic [23:0] remaining;
    logic [23:0] count;
    logic [11:0] src;
    case (phase)
      PH_START: begin
        if (b != MAGIC_L && b != HDR_RAW) begin
          raise_error(ST_NOT_COMP, eoi);
        end else begin
          phase   = (b == MAGIC_L) ? PH_MAGIC : PH_SIZE;
          hdr_idx = '0;
          if (eoi) raise_error(ST_SHORT, eoi);
        end
      end
      PH_MAGIC: begin
        if (hdr_idx > 3'd2 || b != MAGIC_TAIL[8 * (2 - hdr_idx) +: 8]) begin
          raise_error(ST_NOT_COMP, eoi);
        end else begin
          hdr_idx = hdr_idx + 3'd1;
          if (hdr_idx == 3'd3) phase = PH_TYPE;
          if (eoi) raise_error(ST_SHORT, eoi);
        end
      end
      PH_TYPE: begin
        if ((b & TYPE_MASK) != TYPE_VALUE) begin
          raise_error(ST_BAD_TYPE, eoi);
        end else begin
          phase   = PH_SIZE;
          hdr_idx = '0;
          if (eoi) raise_error(ST_SHORT, eoi);
        end
      end
      PH_SIZE: begin
        // size arrives little-endian
        target  = target | (24'(b) << (8 * hdr_idx[1:0]));
        hdr_idx = hdr_idx + 3'd1;
        if (hdr_idx >= 3'd3 && target == '0) begin
          raise_error(ST_ZERO_SIZE, eoi);
        end else begin
          if (hdr_idx >= 3'd3) begin
            phase      = PH_DATA;
            hdr_idx    = '0;
            flags_left = '0;
          end
          if (eoi) raise_error(ST_SHORT, eoi);
        end
      end
      PH_DATA: begin
        if (flags_left == '0) begin
          flags      = b;
          flags_left = 4'd8;
          if (eoi) raise_error(ST_SHORT, eoi);
        end else begin
          is_ref     = flags[7];
          flags      = flags << 1;
          flags_left = flags_left - 4'd1;
          if (is_ref) begin
            token_hi = b;
            phase    = PH_SECOND;
            if (eoi) raise_error(ST_SHORT, eoi);
          end else if (eoi && produced + 1 < target) begin
            raise_error(ST_SHORT, eoi);
          end else begin
            emit_byte(b);
            if (produced == target) close_stream(eoi);
          end
        end
      end
      PH_SECOND: begin
        len = 5'(token_hi[7:4]) + MIN_MATCH;
        off = {1'b0, token_hi[3:0], b} + 13'd1;
        if (off > produced) begin
          raise_error(ST_BAD_OFFSET, eoi);
        end else begin
          // copy is clipped at the declared size
          remaining = target - produced;
          count     = (len < remaining) ? 24'(len) : remaining;
          if (eoi && count < remaining) begin
            raise_error(ST_SHORT, eoi);
          end else begin
            for (int j = 0; j < count; j++) begin
              src = win_ptr - off[11:0];
              emit_byte(history[src]);
            end
            phase = PH_DATA;
            if (produced == target) close_stream(eoi);
          end
        end
      end
      default: begin
        close_stream(eoi);
      end
    endcase
  endtask

  task automatic check_word(input dec_word_t got);
    dec_word_t want;
    checked_words++;
    if (decoded_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte %02h status %0d last %0b",
                                got.data, got.status, got.last));
    end else begin
      want = decoded_due.pop_front();
      if (want.status != ST_DATA) error_words++;
      if (want.last) streams_closed++;
      if (got.data !== want.data)
        report_mismatch($sformatf("byte %02h, expected %02h", got.data, want.data));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      restart_stream();
      decoded_due.delete();
      mismatch_count = 0;
      checked_words  = 0;
      error_words    = 0;
      streams_closed = 0;
    end else begin
      if (stream.valid && stream.ready)
        decode_compressed_byte(stream.in_byte, stream.end_of_input);
      if (result.valid && result.ready)
        check_word('{data: result.out_byte, status: status_t'(result.status),
                     last: result.last});
    end
    pending_words = decoded_due.size();
  end

endmodule

@@ sim/tb_lz77_type10_decompressor_top.sv @@
// stimulus, handshake pacing and verdict for the lz77 type 0x10 decompressor
module tb_lz77_type10_decompressor_top;
  import lz77d_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int QUIET_TAIL   = 30;
  localparam int HOLD_AFTER   = 40;
  localparam int LONG_HOLD    = 150;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } comp_byte_t;

  logic clk;
  logic rst;

  lz77d_in_if  stream_ch ();
  lz77d_out_if result_ch ();

  comp_byte_t byte_plan[$];
  int         sent_count = 0;
  bit         quiet_tail = 1'b0;
  int         idle_cycles;
  int         mismatch_count;
  int         pending_words;
  int         checked_words;
  int         error_words;
  int         streams_closed;

  lz77_type10_decompressor_top u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  lz77_stream_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .stream         (stream_ch),
    .result         (result_ch),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words),
    .checked_words  (checked_words),
    .error_words    (error_words),
    .streams_closed (streams_closed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic push_byte(input logic [7:0] b, input logic e);
    byte_plan.insert(byte_plan.size(), '{data: b, eoi: e});
  endtask

  task automatic mark_end_at(input int idx);
    byte_plan[idx] = '{data: byte_plan[idx].data, eoi: 1'b1};
  endtask

  // either header form, then the 24-bit size little-endian
  task automatic push_header(input logic [23:0] size);
    if ($urandom_range(1) == 1) begin
      push_byte(MAGIC_L, 1'b0);
      push_byte("Z", 1'b0);
      push_byte("7", 1'b0);
      push_byte("7", 1'b0);
      push_byte({4'h1, 4'($urandom)}, 1'b0);
    end else begin
      push_byte(HDR_RAW, 1'b0);
    end
    push_byte(size[7:0], 1'b0);
    push_byte(size[15:8], 1'b0);
    push_byte(size[23:16], 1'b0);
  endtask

  // flag groups of literals and legal back-references up to the given size
  task automatic push_body(input int size, input bit long_refs);
    int         made;
    int         len;
    int         off;
    int         lim;
    logic [7:0] flag;
    logic [7:0] tokens[$];
    made = 0;
    while (made < size) begin
      flag = 8'($urandom);
      tokens.delete();
      for (int i = 7; i >= 0 && made < size; i--) begin
        if (made > 0 && (long_refs ? $urandom_range(15) != 0 : $urandom_range(2) != 0)) begin
          flag[i] = 1'b1;
          len = long_refs ? $urandom_range(15, 18) : $urandom_range(3, 18);
          lim = (made < 4096) ? made : 4096;
          off = ($urandom_range(7) == 0) ? lim : $urandom_range(1, lim);
          tokens.insert(tokens.size(), {4'(len - 3), 4'((off - 1) >> 8)});
          tokens.insert(tokens.size(), 8'(off - 1));
          made += (len < size - made) ? len : size - made;
        end else begin
          flag[i] = 1'b0;
          tokens.insert(tokens.size(), 8'($urandom));
          made++;
        end
      end
      push_byte(flag, 1'b0);
      foreach (tokens[k]) push_byte(tokens[k], 1'b0);
    end
  endtask

  // close a stream, sometimes with trailing bytes that are dropped
  task automatic end_stream();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end
    mark_end_at(byte_plan.size() - 1);
  endtask

  // stream side: build the byte plan, reset, send, then give the verdict
  initial begin : stimulus
    int          kind;
    int          mark;
    int          lits;
    int          off;
    logic [7:0]  flag;
    logic [23:0] size;
    rst                    <= 1'b1;
    stream_ch.valid        <= 1'b0;
    stream_ch.in_byte      <= 8'h00;
    stream_ch.end_of_input <= 1'b0;

    // unknown first byte
    push_byte(8'h00, 1'b1);
    // broken magic after the leading L
    push_byte(MAGIC_L, 1'b0); push_byte("X", 1'b1);
    // input ends inside the header
    push_byte(MAGIC_L, 1'b1);
    // bad type, then a dropped byte up to end of input
    push_byte(MAGIC_L, 1'b0); push_byte("Z", 1'b0); push_byte("7", 1'b0);
    push_byte("7", 1'b0); push_byte(8'h20, 1'b0); push_byte(8'h55, 1'b1);
    // zero size
    push_byte(HDR_RAW, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // back-reference before any byte is produced
    push_byte(HDR_RAW, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // literal ff then a longest copy clipped at the declared size
    push_byte(HDR_RAW, 1'b0); push_byte(8'h04, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h40, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h00, 1'b1);

    // random streams, mostly well formed
    while (byte_plan.size() < RANDOM_ITEMS) begin
      mark = byte_plan.size();
      kind = $urandom_range(19);
      if (kind <= 12) begin
        size = ($urandom_range(9) == 0) ? 24'($urandom_range(40, 120))
                                        : 24'($urandom_range(1, 24));
        push_header(size);
        push_body(size, 1'b0);
        if (kind <= 10) begin
          end_stream();
        end else begin
          // input ends early somewhere in the stream
          byte_plan = byte_plan[0:$urandom_range(mark, byte_plan.size() - 1)];
          mark_end_at(byte_plan.size() - 1);
        end
      end else if (kind == 13) begin
        push_byte(MAGIC_L, 1'b0);
        lits = $urandom_range(2);
        if (lits >= 1) push_byte("Z", 1'b0);
        if (lits == 2) push_byte("7", 1'b0);
        push_byte(8'($urandom), 1'b0);
        end_stream();
      end else if (kind == 14) begin
        push_byte(MAGIC_L, 1'b0); push_byte("Z", 1'b0);
        push_byte("7", 1'b0); push_byte("7", 1'b0);
        push_byte({4'($urandom_range(2, 16)), 4'($urandom)}, 1'b0);
        end_stream();
      end else if (kind == 15) begin
        push_header(24'h000000);
        end_stream();
      end else if (kind == 16) begin
        // reference reaching past the bytes produced so far
        push_header(24'($urandom_range(20, 60)));
        lits = $urandom_range(6);
        flag = 8'($urandom) & (8'hFF >> lits);
        flag[7 - lits] = 1'b1;
        push_byte(flag, 1'b0);
        repeat (lits) push_byte(8'($urandom), 1'b0);
        off = $urandom_range(lits + 1, 4096);
        push_byte({4'($urandom), 4'((off - 1) >> 8)}, 1'b0);
        push_byte(8'(off - 1), 1'b0);
        end_stream();
      end else if (kind == 17) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0);
        end_stream();
      end else begin
        // large declared size, input ends long before it
        size = {8'($urandom_range(1, 255)), 16'($urandom)};
        if ($urandom_range(3) == 0) size = 24'hFFFFFF;
        push_header(size);
        push_body($urandom_range(1, 30), 1'b0);
        mark_end_at(byte_plan.size() - 1);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // send every byte, idling in bursts except near the end
    foreach (byte_plan[i]) begin
      if (i >= byte_plan.size() - QUIET_TAIL) begin
        quiet_tail = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        stream_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      stream_ch.valid        <= 1'b1;
      stream_ch.in_byte      <= byte_plan[i].data;
      stream_ch.end_of_input <= byte_plan[i].eoi;
      do @(posedge clk); while (!stream_ch.ready);
      sent_count++;
    end
    stream_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d compressed words in %0d streams closed,", sent_count,
             streams_closed);
    $display("%0d decoded words checked, %0d of them error words", checked_words,
             error_words);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, none near the end
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER && result_ch.valid) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // stop the run when no word moves on either channel for too long
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
